/* rtl/bmps_pkg.sv */
// Shared types, codes and constants for the bus master poll sequencer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bmps_pkg;

  localparam int MAX_CUPS      = 3;
  localparam int CONFIG_BLOCKS = 5;
  localparam int REQ_W         = 3;
  localparam int CNT_W         = 7;
  localparam int BLK_W         = 3;
  localparam int RETRY_W       = 3;
  localparam int CODE_W        = 4;

  // Reset values of the configuration registers.
  localparam logic [1:0]         CUP_COUNT_RST   = 2'd3;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 3'd5;
  localparam logic [CNT_W-1:0]   QUALITY_MAX_RST = 7'd100;
  localparam logic [CNT_W-1:0]   GOOD_LIMIT_RST  = 7'd90;

  localparam logic [BLK_W-1:0]   LAST_BLOCK = BLK_W'(CONFIG_BLOCKS - 1);

  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_NAME    = 4'd1,
    CMD_STAMP   = 4'd2,
    CMD_CFG     = 4'd3,
    CMD_INPUT   = 4'd4,
    CMD_COILRD  = 4'd5,
    CMD_RECCOIL = 4'd6,
    CMD_FORCE   = 4'd7,
    CMD_CLOSE   = 4'd8,
    CMD_OPEN    = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    REG_CUP_COUNT   = 2'd0,
    REG_RETRY_LIMIT = 2'd1,
    REG_QUALITY_MAX = 2'd2,
    REG_GOOD_LIMIT  = 2'd3
  } reg_idx_t;

  typedef enum logic [11:0] {
    ST_OPEN  = 12'b0000_0000_0001,
    ST_NAME  = 12'b0000_0000_0010,
    ST_STAMP = 12'b0000_0000_0100,
    ST_CFG   = 12'b0000_0000_1000,
    ST_INPUT = 12'b0000_0001_0000,
    ST_COILS = 12'b0000_0010_0000,
    ST_COILW = 12'b0000_0100_0000,
    ST_REC1  = 12'b0000_1000_0000,
    ST_REC2  = 12'b0001_0000_0000,
    ST_REC3  = 12'b0010_0000_0000,
    ST_REC4  = 12'b0100_0000_0000,
    ST_PERM  = 12'b1000_0000_0000
  } state_t;

  typedef struct packed {
    logic [1:0]         cup_count;
    logic [RETRY_W-1:0] retry_limit;
    logic [CNT_W-1:0]   quality_max;
    logic [CNT_W-1:0]   good_limit;
  } cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]  coil_values;
    logic [REQ_W-1:0]  coil_requests;
    logic [REQ_W-1:0]  recovery_requests;
    logic [CODE_W-1:0] outcome_code;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  consecutive_errors;
    logic [CODE_W-1:0] last_failure;
    logic              lockout;
    logic              link_good;
    logic [CNT_W-1:0]  quality_count;
    logic              refresh_display;
    logic              coil_value;
    logic [BLK_W-1:0]  command_index;
    cmd_t              command;
  } result_t;

endpackage

`default_nettype wire

/* rtl/bmps_cfg_regs.sv */
// Configuration register file of the poll sequencer.
// Depends on bmps_pkg for the register indexes and reset values.
`default_nettype none

module bmps_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [6:0]        cfg_data,
  output bmps_pkg::cfg_t         cfg
);
  import bmps_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cup_count   <= CUP_COUNT_RST;
      cfg.retry_limit <= RETRY_LIMIT_RST;
      cfg.quality_max <= QUALITY_MAX_RST;
      cfg.good_limit  <= GOOD_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CUP_COUNT:   cfg.cup_count   <= cfg_data[1:0];
        REG_RETRY_LIMIT: cfg.retry_limit <= cfg_data[RETRY_W-1:0];
        REG_QUALITY_MAX: cfg.quality_max <= cfg_data;
        REG_GOOD_LIMIT:  cfg.good_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/bmps_seq_core.sv */
// Sequencer state, quality counters and the one-tick update logic.
// Depends on bmps_pkg; the result is registered by the top level.
`default_nettype none

module bmps_seq_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire bmps_pkg::item_t   item,
  input  wire bmps_pkg::cfg_t    cfg,
  output bmps_pkg::result_t      result
);
  import bmps_pkg::*;

  state_t             seq_state, seq_state_next, st_eff;
  cmd_t               pending;
  logic [RETRY_W-1:0] retry_count, retry_count_next;
  logic               first_talk, first_talk_next;
  logic [CNT_W-1:0]   success_count, success_count_next;
  logic [CNT_W-1:0]   error_count, error_count_next;
  logic [CODE_W-1:0]  failure_record, failure_record_next;
  logic [BLK_W-1:0]   cfg_block, cfg_block_next;

  logic               fail, handled, do_tally, tally_ok, served;
  cmd_t               cmd;
  logic [BLK_W-1:0]   idx;
  logic               cv, refresh;

  assign fail = (item.outcome_code != '0);

  // Outcome of the previous command, then the next command.
  always_comb begin
    success_count_next  = success_count;
    error_count_next    = error_count;
    failure_record_next = failure_record;
    handled             = 1'b1;
    do_tally            = 1'b0;
    tally_ok            = 1'b0;
    unique case (pending)
      CMD_NAME, CMD_STAMP, CMD_CFG: begin
        if (fail) begin
          failure_record_next = item.outcome_code;
          do_tally            = 1'b1;
        end
      end
      CMD_COILRD: begin
        if (fail) failure_record_next = item.outcome_code;
        do_tally = 1'b1;
        tally_ok = !fail;
      end
      CMD_INPUT, CMD_RECCOIL, CMD_FORCE: begin
        do_tally = 1'b1;
        tally_ok = !fail;
      end
      CMD_OPEN: ;
      default: handled = 1'b0;
    endcase

    if (do_tally) begin
      if (tally_ok) begin
        if (success_count < cfg.quality_max) success_count_next = success_count + 1'b1;
        error_count_next = '0;
      end else begin
        if (error_count < cfg.quality_max) error_count_next = error_count + 1'b1;
        if (success_count != '0) success_count_next = success_count - 1'b1;
      end
    end

    st_eff = (handled && fail) ? ST_REC1 : seq_state;

    seq_state_next   = st_eff;
    retry_count_next = retry_count;
    first_talk_next  = first_talk;
    cfg_block_next   = cfg_block;
    cmd              = CMD_NONE;
    idx              = '0;
    cv               = 1'b0;
    refresh          = 1'b0;
    served           = 1'b0;

    unique case (st_eff)
      ST_OPEN: begin
        if (!first_talk && retry_count >= cfg.retry_limit) begin
          seq_state_next = ST_PERM;
        end else begin
          cmd            = CMD_NAME;
          seq_state_next = ST_NAME;
        end
      end
      ST_NAME: begin
        cmd            = CMD_STAMP;
        seq_state_next = ST_STAMP;
      end
      ST_STAMP: begin
        cmd            = CMD_CFG;
        cfg_block_next = '0;
        seq_state_next = ST_CFG;
      end
      ST_CFG: begin
        if (cfg_block >= LAST_BLOCK) begin
          cmd            = CMD_INPUT;
          seq_state_next = ST_INPUT;
        end else begin
          cfg_block_next = cfg_block + 1'b1;
          cmd            = CMD_CFG;
          idx            = cfg_block + 1'b1;
        end
      end
      ST_INPUT: begin
        cmd            = CMD_COILRD;
        refresh        = 1'b1;
        seq_state_next = ST_COILS;
      end
      ST_COILS: begin
        // Lowest scanned cup wins; recovery beats a forced coil on that cup.
        for (int j = 0; j < MAX_CUPS; j++) begin
          if (!served && j < int'(cfg.cup_count)) begin
            if (item.recovery_requests[j]) begin
              cmd    = CMD_RECCOIL;
              idx    = BLK_W'(j);
              cv     = 1'b1;
              served = 1'b1;
            end else if (item.coil_requests[j]) begin
              cmd    = CMD_FORCE;
              idx    = BLK_W'(j);
              cv     = item.coil_values[j];
              served = 1'b1;
            end
          end
        end
        if (served) begin
          seq_state_next = ST_COILW;
        end else begin
          cmd             = CMD_INPUT;
          seq_state_next  = ST_INPUT;
          first_talk_next = 1'b1;
        end
      end
      ST_COILW: begin
        cmd            = CMD_INPUT;
        seq_state_next = ST_INPUT;
      end
      ST_REC1: begin
        cmd            = CMD_CLOSE;
        seq_state_next = ST_REC2;
      end
      ST_REC2: begin
        refresh        = 1'b1;
        seq_state_next = ST_REC3;
      end
      ST_REC3: seq_state_next = ST_REC4;
      ST_REC4: begin
        cmd            = CMD_OPEN;
        seq_state_next = ST_OPEN;
        if (retry_count < cfg.retry_limit) retry_count_next = retry_count + 1'b1;
      end
      default: seq_state_next = ST_PERM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state      <= ST_OPEN;
      pending        <= CMD_NONE;
      retry_count    <= '0;
      first_talk     <= 1'b0;
      success_count  <= QUALITY_MAX_RST;
      error_count    <= '0;
      failure_record <= '0;
      cfg_block      <= '0;
    end else if (fire) begin
      seq_state      <= seq_state_next;
      pending        <= cmd;
      retry_count    <= retry_count_next;
      first_talk     <= first_talk_next;
      success_count  <= success_count_next;
      error_count    <= error_count_next;
      failure_record <= failure_record_next;
      cfg_block      <= cfg_block_next;
    end
  end

  always_comb begin
    result.command            = cmd;
    result.command_index      = idx;
    result.coil_value         = cv;
    result.refresh_display    = refresh;
    result.quality_count      = success_count_next;
    result.link_good          = (success_count_next > cfg.good_limit);
    result.lockout            = (seq_state_next == ST_PERM);
    result.last_failure       = failure_record_next;
    result.consecutive_errors = error_count_next;
  end

endmodule

`default_nettype wire

/* rtl/bus_master_poll_sequencer.sv */
// Poll sequencer for a bus master: each input word is one poll tick, each
// output word the command to issue next together with link status.
// Uses bmps_pkg, bmps_cfg_regs and bmps_seq_core.
//
// Channels: the slave side (s_tvalid, s_tready, s_tdata) takes one poll tick
// per word: the outcome of the command issued last and the per-cup request
// masks. The master side (m_tvalid, m_tready, m_tdata, m_tuser) gives exactly
// one word per tick, with the command code in m_tuser. The cfg channel writes
// one of four registers; it is always ready and is meant to be used only
// while no tick is in flight.
// Path: an accepted tick waits in the input register until the core fires;
// its word is then held in the output register shown on the master side.
// Throughput: one tick per cycle unless m_tready stalls; the input and output
// registers each hold one word, so a new tick is taken while a result waits.
// Stall: with m_tready low the output word holds, one more tick is taken into
// the input register, and then s_tready drops until the output moves.
// Reset: synchronous; the link restarts at the open step, success count at
// the reset quality maximum, and the registers return to their defaults.
`default_nettype none

module bus_master_poll_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [3:0] outcome_code, [6:4] recovery_requests, [9:7] coil_requests,
  // [12:10] coil_values, [15:13] zero
  input  wire logic [15:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [2:0] command_index, [3] coil_value, [4] refresh_display,
  // [11:5] quality_count, [12] link_good, [13] lockout,
  // [17:14] last_failure, [24:18] consecutive_errors, [31:25] zero
  output logic [31:0]      m_tdata,
  // [3:0] command
  output logic [3:0]       m_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);
  import bmps_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t core_result, out_word;
  logic    advance, fire;

  bmps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bmps_seq_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .cfg    (cfg),
    .result (core_result)
  );

  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_tdata[$bits(item_t)-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= core_result;
    end
  end

  assign m_tuser = out_word.command;
  assign m_tdata = {7'd0, out_word.consecutive_errors, out_word.last_failure,
                    out_word.lockout, out_word.link_good,
                    out_word.quality_count, out_word.refresh_display,
                    out_word.coil_value, out_word.command_index};

endmodule

`default_nettype wire

/* rtl/bmps_checker.sv */
// Port-level checks of the poll sequencer, bound to the top level.
// Depends on bmps_pkg for the command codes.
`default_nettype none

module bmps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [3:0]  m_tuser
);
  import bmps_pkg::*;

  logic perm_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_seen <= 1'b0;
    end else if (m_tvalid && m_tdata[13]) begin
      perm_seen <= 1'b1;
    end
  end

  // A stalled word stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // Permanent error is left only through reset.
  a_perm_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && perm_seen |-> m_tdata[13])
    else $error("permanent error was cleared");

  // A block in permanent error issues nothing.
  a_perm_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[13] |-> m_tuser == CMD_NONE)
    else $error("command issued in permanent error");

  // Only coil writes carry a coil value.
  a_coil_val: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> (m_tuser == CMD_RECCOIL || m_tuser == CMD_FORCE))
    else $error("coil value set on a non-write command");

  // With the output register empty, the input side never stalls.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output");

endmodule

bind bus_master_poll_sequencer bmps_checker u_bmps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
